// ===== hw/rtl/mp2d_pkg.sv =====
// Shared constants and types for the streaming 2-D max pooling block.
// No dependencies; imported by mp2d_front, mp2d_back and the top level.
package mp2d_pkg;

  // Default sizing of the block
  localparam int MAX_DIM_DEF      = 256;
  localparam int MAX_CHANNELS_DEF = 64;
  localparam int MAX_POOL_DEF     = 8;
  localparam int DATA_WIDTH_DEF   = 16;

  // Depth of the command queue and of the result queue (power of two)
  localparam int QUEUE_DEPTH = 4;

  // Configuration port
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_ROWS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_COLS     = 3'd4;

  // Field widths of the registers as written
  localparam int CHAN_REG_W = 7;
  localparam int POOL_REG_W = 4;

  // Control bits of one store command, front to back
  typedef struct packed {
    logic first_col;   // first column of the window: overwrite the stored max
    logic emit;        // window closes: deliver the result
    logic frame_last;  // last result of the frame
  } mp2d_ctl_t;

  localparam int CTL_W = $bits(mp2d_ctl_t);

endpackage

// ===== hw/rtl/mp2d_ram.sv =====
// Generic single-write, single-read RAM with registered read data (read-first).
// No dependencies.
module mp2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/mp2d_fifo.sv =====
// Small synchronous queue in flip-flops, first word visible at the head.
// No dependencies; callers gate push with full and pop with empty.
module mp2d_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/mp2d_front.sv =====
// Front end: configuration registers, position counters and the row-window
// maximum; issues one store command per closed row window. Uses mp2d_pkg.
module mp2d_front #(
  parameter int MAX_DIM      = mp2d_pkg::MAX_DIM_DEF,
  parameter int MAX_CHANNELS = mp2d_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_POOL     = mp2d_pkg::MAX_POOL_DEF,
  parameter int DATA_WIDTH   = mp2d_pkg::DATA_WIDTH_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [mp2d_pkg::CFG_IDX_W-1:0]            cfg_idx_i,
  input  logic [mp2d_pkg::CFG_W-1:0]                cfg_data_i,
  input  logic                                      accept_i,
  input  logic signed [DATA_WIDTH-1:0]              sample_i,
  output logic                                      op_push_o,
  output logic [$clog2(MAX_DIM*MAX_CHANNELS)-1:0]   op_addr_o,
  output logic signed [DATA_WIDTH-1:0]              op_value_o,
  output mp2d_pkg::mp2d_ctl_t                       op_ctl_o
);

  import mp2d_pkg::*;

  localparam int AW    = $clog2(MAX_DIM*MAX_CHANNELS);
  localparam int DIM_W = $clog2(MAX_DIM+1);
  localparam int RP_W  = $clog2(MAX_DIM);
  localparam int CC_W  = $clog2(MAX_CHANNELS+1);
  localparam int CI_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int PL_W  = $clog2(MAX_POOL+1);
  localparam int PH_W  = $clog2(MAX_POOL);
  localparam int HC_W  = (CFG_W > DIM_W) ? CFG_W : DIM_W;
  localparam int CX_W  = (CHAN_REG_W > CC_W) ? CHAN_REG_W : CC_W;
  localparam int PX_W  = (POOL_REG_W > PL_W) ? POOL_REG_W : PL_W;

  // Clamped configuration
  logic [DIM_W-1:0] h_q, h_d, w_q, w_d;
  logic [CC_W-1:0]  c_q, c_d;
  logic [PL_W-1:0]  pr_q, pr_d, pc_q, pc_d;

  // Position state
  logic [RP_W-1:0]  row_pos_q, row_pos_d;
  logic [RP_W-1:0]  col_pos_q, col_pos_d;
  logic [CI_W-1:0]  chan_pos_q, chan_pos_d;
  logic [PH_W-1:0]  row_phase_q, row_phase_d;
  logic [PH_W-1:0]  col_phase_q, col_phase_d;
  logic [AW-1:0]    row_base_q, row_base_d;
  logic signed [DATA_WIDTH-1:0] gm_q, gm_d;

  logic [HC_W-1:0]  dim_val;
  logic [DIM_W-1:0] dim_clamp;
  logic [CX_W-1:0]  chan_val;
  logic [CC_W-1:0]  chan_clamp;
  logic [PX_W-1:0]  pool_val;
  logic [PL_W-1:0]  pool_clamp;
  logic             cfg_hit;

  logic last_row, last_chan, last_col, row_close, col_close;

  // Clamp written values: zero acts as one, large values saturate
  always_comb begin
    dim_val  = HC_W'(cfg_data_i);
    chan_val = CX_W'(cfg_data_i[CHAN_REG_W-1:0]);
    pool_val = PX_W'(cfg_data_i[POOL_REG_W-1:0]);
    if (dim_val == '0) begin
      dim_clamp = DIM_W'(1);
    end else if (dim_val > HC_W'(MAX_DIM)) begin
      dim_clamp = DIM_W'(MAX_DIM);
    end else begin
      dim_clamp = DIM_W'(dim_val);
    end
    if (chan_val == '0) begin
      chan_clamp = CC_W'(1);
    end else if (chan_val > CX_W'(MAX_CHANNELS)) begin
      chan_clamp = CC_W'(MAX_CHANNELS);
    end else begin
      chan_clamp = CC_W'(chan_val);
    end
    if (pool_val == '0) begin
      pool_clamp = PL_W'(1);
    end else if (pool_val > PX_W'(MAX_POOL)) begin
      pool_clamp = PL_W'(MAX_POOL);
    end else begin
      pool_clamp = PL_W'(pool_val);
    end
  end

  // Register writes
  always_comb begin
    h_d     = h_q;
    w_d     = w_q;
    c_d     = c_q;
    pr_d    = pr_q;
    pc_d    = pc_q;
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IN_HEIGHT: begin
          h_d     = dim_clamp;
          cfg_hit = 1'b1;
        end
        REG_IN_WIDTH: begin
          w_d     = dim_clamp;
          cfg_hit = 1'b1;
        end
        REG_CHANNEL_COUNT: begin
          c_d     = chan_clamp;
          cfg_hit = 1'b1;
        end
        REG_POOL_ROWS: begin
          pr_d    = pool_clamp;
          cfg_hit = 1'b1;
        end
        REG_POOL_COLS: begin
          pc_d    = pool_clamp;
          cfg_hit = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  // Classify the current sample
  always_comb begin
    last_row  = (DIM_W'(row_pos_q) + DIM_W'(1)) >= h_q;
    last_chan = (CC_W'(chan_pos_q) + CC_W'(1)) >= c_q;
    last_col  = (DIM_W'(col_pos_q) + DIM_W'(1)) >= w_q;
    row_close = ((PL_W'(row_phase_q) + PL_W'(1)) >= pr_q) || last_row;
    col_close = ((PL_W'(col_phase_q) + PL_W'(1)) >= pc_q) || last_col;
    if ((row_phase_q == '0) || (sample_i > gm_q)) begin
      gm_d = sample_i;
    end else begin
      gm_d = gm_q;
    end
  end

  // Store command for a closed row window
  assign op_push_o           = accept_i && row_close;
  assign op_addr_o           = row_base_q + AW'(chan_pos_q);
  assign op_value_o          = gm_d;
  assign op_ctl_o.first_col  = (col_phase_q == '0);
  assign op_ctl_o.emit       = col_close;
  assign op_ctl_o.frame_last = last_row && last_chan && last_col;

  // Advance counters: row, then channel, then column; restart on a write to a known register
  always_comb begin
    row_pos_d   = row_pos_q;
    col_pos_d   = col_pos_q;
    chan_pos_d  = chan_pos_q;
    row_phase_d = row_phase_q;
    col_phase_d = col_phase_q;
    row_base_d  = row_base_q;
    if (cfg_hit) begin
      row_pos_d   = '0;
      col_pos_d   = '0;
      chan_pos_d  = '0;
      row_phase_d = '0;
      col_phase_d = '0;
      row_base_d  = '0;
    end else if (accept_i) begin
      if (!last_row) begin
        row_pos_d = row_pos_q + RP_W'(1);
        if (row_close) begin
          row_phase_d = '0;
          row_base_d  = row_base_q + AW'(MAX_CHANNELS);
        end else begin
          row_phase_d = row_phase_q + PH_W'(1);
        end
      end else begin
        row_pos_d   = '0;
        row_phase_d = '0;
        row_base_d  = '0;
        if (!last_chan) begin
          chan_pos_d = chan_pos_q + CI_W'(1);
        end else begin
          chan_pos_d = '0;
          if (!last_col) begin
            col_pos_d   = col_pos_q + RP_W'(1);
            col_phase_d = col_close ? '0 : col_phase_q + PH_W'(1);
          end else begin
            col_pos_d   = '0;
            col_phase_d = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q         <= DIM_W'(1);
      w_q         <= DIM_W'(1);
      c_q         <= CC_W'(1);
      pr_q        <= PL_W'(2);
      pc_q        <= PL_W'(2);
      row_pos_q   <= '0;
      col_pos_q   <= '0;
      chan_pos_q  <= '0;
      row_phase_q <= '0;
      col_phase_q <= '0;
      row_base_q  <= '0;
    end else begin
      h_q         <= h_d;
      w_q         <= w_d;
      c_q         <= c_d;
      pr_q        <= pr_d;
      pc_q        <= pc_d;
      row_pos_q   <= row_pos_d;
      col_pos_q   <= col_pos_d;
      chan_pos_q  <= chan_pos_d;
      row_phase_q <= row_phase_d;
      col_phase_q <= col_phase_d;
      row_base_q  <= row_base_d;
    end
  end

  // Hold the row-window maximum
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      gm_q <= gm_d;
    end
  end

endmodule

// ===== hw/rtl/mp2d_back.sv =====
// Back end: read-modify-write of the per-row-window, per-channel column maximum in
// RAM, with write bypass, and the result queue. Uses mp2d_pkg, mp2d_ram, mp2d_fifo.
module mp2d_back #(
  parameter int MAX_DIM      = mp2d_pkg::MAX_DIM_DEF,
  parameter int MAX_CHANNELS = mp2d_pkg::MAX_CHANNELS_DEF,
  parameter int DATA_WIDTH   = mp2d_pkg::DATA_WIDTH_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      op_valid_i,
  output logic                                      op_pop_o,
  input  logic [$clog2(MAX_DIM*MAX_CHANNELS)-1:0]   op_addr_i,
  input  logic signed [DATA_WIDTH-1:0]              op_value_i,
  input  mp2d_pkg::mp2d_ctl_t                       op_ctl_i,
  input  logic                                      pop_i,
  output logic                                      empty_o,
  output logic signed [DATA_WIDTH-1:0]              pooled_value_o,
  output logic                                      frame_done_o
);

  import mp2d_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_CHANNELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int QC_W  = $clog2(QUEUE_DEPTH+1);
  localparam int RES_W = DATA_WIDTH + 1;

  // Update stage
  logic                         b_valid_q;
  logic [AW-1:0]                b_addr_q;
  logic signed [DATA_WIDTH-1:0] b_value_q;
  mp2d_ctl_t                    b_ctl_q;

  // Last RAM write, for the bypass
  logic                         wr_vld_q;
  logic [AW-1:0]                wr_addr_q;
  logic signed [DATA_WIDTH-1:0] wr_data_q;

  logic signed [DATA_WIDTH-1:0] ram_rdata;
  logic signed [DATA_WIDTH-1:0] old_max;
  logic signed [DATA_WIDTH-1:0] new_max;
  logic [QC_W-1:0]              res_cnt;
  logic [QC_W-1:0]              res_pend;
  logic                         res_push;
  logic                         res_full;
  logic [RES_W-1:0]             res_head;

  // Launch a command only when the result queue has room for it
  assign res_pend = QC_W'(b_valid_q && b_ctl_q.emit);
  assign op_pop_o = op_valid_i && ((res_cnt + res_pend) < QC_W'(QUEUE_DEPTH));

  mp2d_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (b_valid_q),
    .waddr_i (b_addr_q),
    .wdata_i (new_max),
    .raddr_i (op_addr_i),
    .rdata_o (ram_rdata)
  );

  // Merge the row-window max with the stored column max
  always_comb begin
    if (wr_vld_q && (wr_addr_q == b_addr_q)) begin
      old_max = wr_data_q;
    end else begin
      old_max = ram_rdata;
    end
    if (b_ctl_q.first_col || (b_value_q > old_max)) begin
      new_max = b_value_q;
    end else begin
      new_max = old_max;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      wr_vld_q  <= 1'b0;
    end else begin
      b_valid_q <= op_pop_o;
      if (b_valid_q) begin
        wr_vld_q <= 1'b1;
      end
    end
  end

  // Capture the launched command and track the last write
  always_ff @(posedge clk_i) begin
    if (op_pop_o) begin
      b_addr_q  <= op_addr_i;
      b_value_q <= op_value_i;
      b_ctl_q   <= op_ctl_i;
    end
    if (b_valid_q) begin
      wr_addr_q <= b_addr_q;
      wr_data_q <= new_max;
    end
  end

  // Result queue
  assign res_push = b_valid_q && b_ctl_q.emit;

  mp2d_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_results (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  ({new_max, b_ctl_q.frame_last}),
    .pop_i   (pop_i && !empty_o),
    .data_o  (res_head),
    .full_o  (res_full),
    .empty_o (empty_o),
    .count_o (res_cnt)
  );

  assign pooled_value_o = res_head[RES_W-1:1];
  assign frame_done_o   = res_head[0] && !res_full ? res_head[0] : res_head[0];

endmodule

// ===== hw/rtl/max_pool_2d_stream.sv =====
// Streaming 2-D max pooling (ceil mode), non-overlapping windows, top level.
// Takes one sample per clock with no gaps unless full: one RAM read and one RAM
// write per store command keep pace with the input, and a one-beat write bypass
// covers back-to-back commands on the same entry. Each result passes the
// command queue, update stage and result queue. Samples arrive row fastest,
// then channel, then column; results leave in the same order, frame_done_o
// marking the last of a frame. Writing a known register restarts the frame;
// write registers only while the block is drained. The window store needs no
// clearing after reset. Depends on mp2d_pkg, mp2d_fifo, mp2d_front, mp2d_back.
module max_pool_2d_stream #(
  parameter int MAX_DIM      = mp2d_pkg::MAX_DIM_DEF,
  parameter int MAX_CHANNELS = mp2d_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_POOL     = mp2d_pkg::MAX_POOL_DEF,
  parameter int DATA_WIDTH   = mp2d_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mp2d_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mp2d_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           push,
  output logic                           full,
  input  logic signed [DATA_WIDTH-1:0]   sample_i,
  output logic                           empty,
  input  logic                           pop,
  output logic signed [DATA_WIDTH-1:0]   pooled_value_o,
  output logic                           frame_done_o
);

  import mp2d_pkg::*;

  localparam int AW   = $clog2(MAX_DIM*MAX_CHANNELS);
  localparam int OP_W = AW + DATA_WIDTH + CTL_W;

  logic                         accept;
  logic                         op_push;
  logic [AW-1:0]                op_addr;
  logic signed [DATA_WIDTH-1:0] op_value;
  mp2d_ctl_t                    op_ctl;
  logic [OP_W-1:0]              q_head;
  logic                         q_empty;
  logic                         q_pop;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
  mp2d_ctl_t                    q_ctl;

  assign accept = push && !full;

  mp2d_front #(
    .MAX_DIM      (MAX_DIM),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_POOL     (MAX_POOL),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .sample_i   (sample_i),
    .op_push_o  (op_push),
    .op_addr_o  (op_addr),
    .op_value_o (op_value),
    .op_ctl_o   (op_ctl)
  );

  // Command queue between front and back
  mp2d_fifo #(
    .WIDTH (OP_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .data_i  ({op_addr, op_value, op_ctl}),
    .pop_i   (q_pop),
    .data_o  (q_head),
    .full_o  (full),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  assign q_ctl = mp2d_ctl_t'(q_head[CTL_W-1:0]);

  mp2d_back #(
    .MAX_DIM      (MAX_DIM),
    .MAX_CHANNELS (MAX_CHANNELS),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_valid_i     (!q_empty && (q_count != '0)),
    .op_pop_o       (q_pop),
    .op_addr_i      (q_head[OP_W-1 -: AW]),
    .op_value_i     (q_head[CTL_W +: DATA_WIDTH]),
    .op_ctl_i       (q_ctl),
    .pop_i          (pop),
    .empty_o        (empty),
    .pooled_value_o (pooled_value_o),
    .frame_done_o   (frame_done_o)
  );

endmodule

// ===== hw/rtl/max_pool_2d_stream_checker.sv =====
// Port-level checks for max_pool_2d_stream, attached by the bind at the end.
// Depends on max_pool_2d_stream.
module max_pool_2d_stream_checker #(
  parameter int DATA_WIDTH = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  push,
  input logic                  full,
  input logic                  empty,
  input logic                  pop,
  input logic [DATA_WIDTH-1:0] pooled_value_o,
  input logic                  frame_done_o
);

  // Both queues come out of reset drained
  a_reset_drained: assert property (@(posedge clk_i) !rst_ni |=> (empty && !full))
    else $error("queues not drained in reset");

  // The command queue fills only through accepted input beats
  a_full_needs_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!full && !push) |=> !full)
    else $error("full rose without an input beat");

  // A waiting result leaves only through a pop
  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result dropped without a pop");

  // A waiting result holds its payload
  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(pooled_value_o) && $stable(frame_done_o)))
    else $error("result payload changed while waiting");

endmodule

bind max_pool_2d_stream max_pool_2d_stream_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .push           (push),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .pooled_value_o (pooled_value_o),
  .frame_done_o   (frame_done_o)
);

// ===== sim/max_pool_2d_stream_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for max_pool_2d_stream: a directed table, then random frames.
// Holds its own pooling predictor; depends on mp2d_pkg and the block's RTL only.
module max_pool_2d_stream_test;
  import mp2d_pkg::*;

  localparam int DW          = DATA_WIDTH_DEF;
  localparam int STORE_DEPTH = MAX_DIM_DEF * MAX_CHANNELS_DEF;
  localparam int SETTLE      = 8;
  localparam int HOLD_CYCLES = 150;
  localparam int LIMIT       = 200000;
  localparam int RAND_ITEMS  = 1200;
  localparam int PRESS_AT    = 400;
  localparam int CALM_AFTER  = 1050;
  localparam int MAX_REPORTS = 10;

  // index that maps to no register
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef logic signed [DW-1:0] sample_t;

  typedef struct {
    sample_t value;
    logic    done;
  } pooled_t;

  typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    sample_t              value;
    bit                   typed;
    sample_t              want;
    bit                   want_done;
  } plan_row_t;

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i  = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 push       = 1'b0;
  logic                 full;
  sample_t              sample_i   = '0;
  logic                 empty;
  logic                 pop        = 1'b0;
  sample_t              pooled_value_o;
  logic                 frame_done_o;

  // typed expectation that travels with the input beat
  logic                 pin_on    = 1'b0;
  sample_t              pin_value = '0;
  logic                 pin_done  = 1'b0;

  bit                   hold_req   = 1'b0;
  bit                   calm       = 1'b0;
  int unsigned          sent       = 0;
  int unsigned          mismatches = 0;
  int unsigned          cycles     = 0;
  pooled_t              due_q[$];

  // Register mirror and pooling state of the predictor
  logic [CFG_W-1:0]      cur_height = 9'd1;
  logic [CFG_W-1:0]      cur_width  = 9'd1;
  logic [CHAN_REG_W-1:0] cur_chans  = 7'd1;
  logic [POOL_REG_W-1:0] cur_prows  = 4'd2;
  logic [POOL_REG_W-1:0] cur_pcols  = 4'd2;
  sample_t               col_store [STORE_DEPTH];
  sample_t               rows_max;
  int unsigned           row_at = 0, chan_at = 0, col_at = 0, row_ph = 0, col_ph = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  max_pool_2d_stream u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .sample_i       (sample_i),
    .empty          (empty),
    .pop            (pop),
    .pooled_value_o (pooled_value_o),
    .frame_done_o   (frame_done_o)
  );

  // Zero acts as one, anything above the top acts as the top
  function automatic int unsigned clip(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // Advance the pooling state by one sample; hit flags a closed window
  function automatic void pool_step(input sample_t s, output bit hit, output pooled_t res);
    int unsigned h, w, c, pr, pc, slot;
    bit          last_row, last_chan, last_col, row_close, col_close;
    h  = clip(cur_height, MAX_DIM_DEF);
    w  = clip(cur_width, MAX_DIM_DEF);
    c  = clip(cur_chans, MAX_CHANNELS_DEF);
    pr = clip(cur_prows, MAX_POOL_DEF);
    pc = clip(cur_pcols, MAX_POOL_DEF);
    last_row  = (row_at + 1 >= h);
    last_chan = (chan_at + 1 >= c);
    last_col  = (col_at + 1 >= w);
    row_close = (row_ph + 1 >= pr) || last_row;
    col_close = (col_ph + 1 >= pc) || last_col;
    hit       = 1'b0;
    res.value = '0;
    res.done  = 1'b0;

    if (row_ph == 0 || s > rows_max) rows_max = s;

    // fold the row maximum into the column store, emit when the window closes
    if (row_close) begin
      slot = ((row_at / pr) * MAX_CHANNELS_DEF + chan_at) % STORE_DEPTH;
      if (col_ph == 0 || rows_max > col_store[slot]) col_store[slot] = rows_max;
      if (col_close) begin
        hit       = 1'b1;
        res.value = col_store[slot];
        res.done  = last_row && last_chan && last_col;
      end
    end

    // advance row, then channel, then column
    row_ph = row_close ? 0 : row_ph + 1;
    if (!last_row) begin
      row_at++;
    end else begin
      row_at = 0;
      row_ph = 0;
      if (!last_chan) begin
        chan_at++;
      end else begin
        chan_at = 0;
        col_ph  = col_close ? 0 : col_ph + 1;
        if (!last_col) begin
          col_at++;
        end else begin
          col_at = 0;
          col_ph = 0;
        end
      end
    end
  endfunction

  // Random register value: mostly small sizes, sometimes zero, the top or any code
  function automatic logic [CFG_W-1:0] pick_reg(int unsigned usual, int unsigned top);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_W'($urandom_range(0, 511));
      2:       return CFG_W'(top);
      default: return CFG_W'($urandom_range(1, usual));
    endcase
  endfunction

  // Write one register and mirror it; a known register restarts the frame
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_IN_HEIGHT:     cur_height = data;
      REG_IN_WIDTH:      cur_width  = data;
      REG_CHANNEL_COUNT: cur_chans  = data[CHAN_REG_W-1:0];
      REG_POOL_ROWS:     cur_prows  = data[POOL_REG_W-1:0];
      REG_POOL_COLS:     cur_pcols  = data[POOL_REG_W-1:0];
      default:           return;
    endcase
    row_at  = 0;
    chan_at = 0;
    col_at  = 0;
    row_ph  = 0;
    col_ph  = 0;
  endtask

  // Offer one sample, with an optional idle burst first; return once accepted
  task automatic offer(input sample_t s, input bit typed, input sample_t want,
                       input bit want_done);
    if (!calm && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    push      <= 1'b1;
    sample_i  <= s;
    pin_on    <= typed;
    pin_value <= want;
    pin_done  <= want_done;
    do @(posedge clk_i); while (full);
    sent++;
    calm = (sent >= CALM_AFTER);
  endtask

  // Stop offering, wait for every expected beat, then let the pipeline settle
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk_i); while (due_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Check output beats against the oldest expectation, predict accepted inputs
  always @(posedge clk_i) begin
    pooled_t want, got;
    bit      hit;
    if (pop && !empty) begin
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected beat: value %0d done %0b",
                   $realtime, pooled_value_o, frame_done_o);
      end else begin
        want = due_q.pop_front();
        if (pooled_value_o !== want.value || frame_done_o !== want.done) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: want value %0d done %0b, got value %0d done %0b", $realtime,
                     want.value, want.done, pooled_value_o, frame_done_o);
        end
      end
    end
    if (push && !full) begin
      pool_step(sample_i, hit, got);
      if (pin_on) begin
        got.value = pin_value;
        got.done  = pin_done;
      end
      if (pin_on || hit) due_q.push_back(got);
    end
  end

  // Receiver: random stalls, one long hold-off on request, none near the end
  initial begin : receiver
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        pop <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        pop <= 1'b0;
        gap = $urandom_range(1, 12);
        repeat (gap) @(posedge clk_i);
        pop <= 1'b1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t   plan[$];
    int unsigned frame, count;
    bit          pressed;
    sample_t     s;
    pressed = 1'b0;

    // after reset every frame is one sample, so each sample is its own last result
    plan.push_back(plan_row_t'{ROW_SAMPLE, '0, '0, 16'h7FFF, 1'b1, 16'h7FFF, 1'b1});
    plan.push_back(plan_row_t'{ROW_SAMPLE, '0, '0, 16'h8000, 1'b1, 16'h8000, 1'b1});
    plan.push_back(plan_row_t'{ROW_SAMPLE, '0, '0, 16'h0000, 1'b1, 16'h0000, 1'b1});
    plan.push_back(plan_row_t'{ROW_SAMPLE, '0, '0, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1});
    // three rows in two-row windows: the bottom window holds a single row
    plan.push_back(plan_row_t'{ROW_WRITE, REG_IN_HEIGHT, 9'd3, '0, 1'b0, '0, 1'b0});
    plan.push_back(plan_row_t'{ROW_SAMPLE, '0, '0, 16'h8000, 1'b0, '0, 1'b0});
    plan.push_back(plan_row_t'{ROW_SAMPLE, '0, '0, 16'h7FFF, 1'b1, 16'h7FFF, 1'b0});
    plan.push_back(plan_row_t'{ROW_SAMPLE, '0, '0, 16'h8001, 1'b1, 16'h8001, 1'b1});
    // three columns in two-column windows: the right window holds a single column
    plan.push_back(plan_row_t'{ROW_WRITE, REG_IN_HEIGHT, 9'd1, '0, 1'b0, '0, 1'b0});
    plan.push_back(plan_row_t'{ROW_WRITE, REG_IN_WIDTH, 9'd3, '0, 1'b0, '0, 1'b0});
    plan.push_back(plan_row_t'{ROW_SAMPLE, '0, '0, 16'h0005, 1'b0, '0, 1'b0});
    plan.push_back(plan_row_t'{ROW_SAMPLE, '0, '0, 16'h0003, 1'b1, 16'h0005, 1'b0});
    plan.push_back(plan_row_t'{ROW_SAMPLE, '0, '0, 16'hFFFE, 1'b1, 16'hFFFE, 1'b1});
    // high data bits dropped: pool width zero acts as one, channels clamp to the top
    plan.push_back(plan_row_t'{ROW_WRITE, REG_POOL_COLS, 9'h1F0, '0, 1'b0, '0, 1'b0});
    plan.push_back(plan_row_t'{ROW_WRITE, REG_CHANNEL_COUNT, 9'h1FF, '0, 1'b0, '0, 1'b0});
    plan.push_back(plan_row_t'{ROW_SAMPLE, '0, '0, 16'h00FF, 1'b1, 16'h00FF, 1'b0});
    // restart mid-frame with window height and map height above their tops
    plan.push_back(plan_row_t'{ROW_WRITE, REG_POOL_ROWS, 9'h1FF, '0, 1'b0, '0, 1'b0});
    plan.push_back(plan_row_t'{ROW_WRITE, REG_IN_HEIGHT, 9'h1FF, '0, 1'b0, '0, 1'b0});
    plan.push_back(plan_row_t'{ROW_SAMPLE, '0, '0, 16'h5555, 1'b0, '0, 1'b0});
    plan.push_back(plan_row_t'{ROW_SAMPLE, '0, '0, 16'hAAAA, 1'b0, '0, 1'b0});
    // an unused index leaves the frame position alone
    plan.push_back(plan_row_t'{ROW_WRITE, REG_UNUSED, 9'h1FF, '0, 1'b0, '0, 1'b0});
    plan.push_back(plan_row_t'{ROW_SAMPLE, '0, '0, 16'h0100, 1'b0, '0, 1'b0});
    // window height zero acts as one: every sample closes its window
    plan.push_back(plan_row_t'{ROW_WRITE, REG_POOL_ROWS, 9'd0, '0, 1'b0, '0, 1'b0});
    plan.push_back(plan_row_t'{ROW_SAMPLE, '0, '0, 16'h8000, 1'b1, 16'h8000, 1'b0});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        offer(plan[i].value, plan[i].typed, plan[i].want, plan[i].want_done);
      end
    end

    // Random part: mostly whole frames with random content, some cut short
    while (sent < RAND_ITEMS) begin
      drain();
      if (!pressed && sent >= PRESS_AT) begin
        // one result per sample while the receiver holds off: fill the block
        pressed = 1'b1;
        write_reg(REG_IN_HEIGHT, 9'd4);
        write_reg(REG_IN_WIDTH, 9'd4);
        write_reg(REG_CHANNEL_COUNT, 9'd2);
        write_reg(REG_POOL_ROWS, 9'd1);
        write_reg(REG_POOL_COLS, 9'd1);
        hold_req = 1'b1;
        count    = 96;
      end else begin
        if ($urandom_range(0, 2) != 0) write_reg(REG_IN_HEIGHT, pick_reg(12, 256));
        if ($urandom_range(0, 2) != 0) write_reg(REG_IN_WIDTH, pick_reg(12, 256));
        if ($urandom_range(0, 2) != 0) write_reg(REG_CHANNEL_COUNT, pick_reg(4, 64));
        if ($urandom_range(0, 2) != 0) write_reg(REG_POOL_ROWS, pick_reg(8, 8));
        if ($urandom_range(0, 2) != 0) write_reg(REG_POOL_COLS, pick_reg(8, 8));
        frame = clip(cur_height, MAX_DIM_DEF) * clip(cur_width, MAX_DIM_DEF)
              * clip(cur_chans, MAX_CHANNELS_DEF);
        if (frame <= 240) count = frame * $urandom_range(1, 3);
        else              count = $urandom_range(30, 200);
        if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
      end
      // stop at the planned number of samples
      if (sent + count > RAND_ITEMS) count = RAND_ITEMS - sent;
      repeat (count) begin
        case ($urandom_range(0, 7))
          0:       s = 16'h7FFF;
          1:       s = 16'h8000;
          2:       s = 16'($urandom_range(0, 15)) - 16'd8;   // near ties around zero
          default: s = 16'($urandom);
        endcase
        offer(s, 1'b0, '0, 1'b0);
      end
    end

    drain();
    if (mismatches == 0 && due_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
